// ----- hdl/crcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, result codes and the CRC-16 byte step for the framed packet
// receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

   // result kinds
   localparam logic [2:0] KIND_PARAM    = 3'd0;
   localparam logic [2:0] KIND_GOOD     = 3'd1;
   localparam logic [2:0] KIND_BAD      = 3'd2;
   localparam logic [2:0] KIND_TIMEOUT  = 3'd3;
   localparam logic [2:0] KIND_OVERFLOW = 3'd4;

   // request commands
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   // header bytes and crc polynomial
   localparam logic [7:0]  HDR_FF   = 8'hFF;
   localparam logic [7:0]  HDR_FD   = 8'hFD;
   localparam logic [15:0] CRC_POLY = 16'h8005;

   // one result item
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data_byte;
      logic [5:0] param_index;
      logic [7:0] frame_id;
      logic [7:0] frame_instruction;
      logic [5:0] param_count;
   } rsp_type;

   // crc-16 over one byte, msb first, no reflection
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // crc after the three header bytes
   localparam logic [15:0] HDR_CRC = crc_byte(crc_byte(crc_byte(16'h0000, HDR_FF), HDR_FF),
                                              HDR_FD);

endpackage

// ----- hdl/crcfr_parser.sv -----
// ----------------------------------------------------------------------------
// crcfr_parser
// Frame state machine: header hunt, field capture, running crc and checksum
// compare. Takes one event per step and gives zero or one result.
// ----------------------------------------------------------------------------
module crcfr_parser
   import crcfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic       cmd,
   input  logic [7:0] byte_value,
   output logic       res_valid,
   output rsp_type    res
);

   localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_FRAME_BYTES);

   // phase codes
   localparam logic [3:0] PH_HUNT1 = 4'd0;
   localparam logic [3:0] PH_HUNT2 = 4'd1;
   localparam logic [3:0] PH_HUNT3 = 4'd2;
   localparam logic [3:0] PH_RESV  = 4'd3;
   localparam logic [3:0] PH_ID    = 4'd4;
   localparam logic [3:0] PH_LENLO = 4'd5;
   localparam logic [3:0] PH_LENHI = 4'd6;
   localparam logic [3:0] PH_INSTR = 4'd7;
   localparam logic [3:0] PH_PARAM = 4'd8;
   localparam logic [3:0] PH_CKLO  = 4'd9;
   localparam logic [3:0] PH_CKHI  = 4'd10;

   logic [3:0]    phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   length_ff, length_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    id_ff, id_in;
   logic [7:0]    instr_ff, instr_in;
   logic [7:0]    cklo_ff, cklo_in;

   logic [CW-1:0] count_inc;
   logic [16:0]   frame_end;
   logic          at_end;
   logic [15:0]   crc_next;
   logic [15:0]   idx_wide;
   logic [15:0]   len_m3;
   logic [5:0]    pcount;

   // shared datapath pieces
   always_comb begin
      count_inc = count_ff + CW'(1);
      frame_end = {1'b0, length_ff} + 17'd5;
      at_end    = 17'(count_inc) >= frame_end;
      crc_next  = crc_byte(crc_ff, byte_value);
      idx_wide  = 16'(count_inc) - 16'd9;
      len_m3    = length_ff - 16'd3;
      pcount    = (length_ff >= 16'd3) ? len_m3[5:0] : 6'd0;
   end

   // next state and result
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      crc_in    = crc_ff;
      id_in     = id_ff;
      instr_in  = instr_ff;
      cklo_in   = cklo_ff;
      res_valid = 1'b0;
      res       = '0;
      if (cmd == CMD_TIMEOUT) begin
         res_valid = 1'b1;
         res.kind  = KIND_TIMEOUT;
         phase_in  = PH_HUNT1;
         count_in  = '0;
      end else if (phase_ff == PH_HUNT3 && byte_value == HDR_FF) begin
         // extra ff before fd is dropped uncounted
         phase_in = phase_ff;
      end else if (count_inc >= MAX_COUNT) begin
         res_valid = 1'b1;
         res.kind  = KIND_OVERFLOW;
         phase_in  = PH_HUNT1;
         count_in  = '0;
      end else begin
         count_in = count_inc;
         case (phase_ff)
            PH_HUNT2: begin
               if (byte_value == HDR_FF) begin
                  phase_in = PH_HUNT3;
               end else begin
                  phase_in = PH_HUNT1;
                  count_in = '0;
               end
            end
            PH_HUNT3: begin
               if (byte_value == HDR_FD) begin
                  crc_in   = HDR_CRC;
                  phase_in = PH_RESV;
               end else begin
                  phase_in = PH_HUNT1;
                  count_in = '0;
               end
            end
            PH_RESV: begin
               crc_in   = crc_next;
               phase_in = PH_ID;
            end
            PH_ID: begin
               crc_in   = crc_next;
               id_in    = byte_value;
               phase_in = PH_LENLO;
            end
            PH_LENLO: begin
               crc_in    = crc_next;
               length_in = {8'h00, byte_value};
               phase_in  = PH_LENHI;
            end
            PH_LENHI: begin
               crc_in    = crc_next;
               length_in = {byte_value, length_ff[7:0]};
               phase_in  = PH_INSTR;
            end
            PH_INSTR: begin
               crc_in   = crc_next;
               instr_in = byte_value;
               phase_in = at_end ? PH_CKLO : PH_PARAM;
            end
            PH_PARAM: begin
               crc_in                = crc_next;
               res_valid             = 1'b1;
               res.kind              = KIND_PARAM;
               res.data_byte         = byte_value;
               res.param_index       = idx_wide[5:0];
               res.frame_id          = id_ff;
               res.frame_instruction = instr_ff;
               res.param_count       = pcount;
               if (at_end) begin
                  phase_in = PH_CKLO;
               end
            end
            PH_CKLO: begin
               cklo_in  = byte_value;
               phase_in = PH_CKHI;
            end
            PH_CKHI: begin
               res_valid             = 1'b1;
               res.kind              = (length_ff >= 16'd3 && {byte_value, cklo_ff} == crc_ff)
                                       ? KIND_GOOD : KIND_BAD;
               res.frame_id          = id_ff;
               res.frame_instruction = instr_ff;
               res.param_count       = pcount;
               phase_in              = PH_HUNT1;
               count_in              = '0;
            end
            default: begin
               // first header byte, also for unused codes
               if (byte_value == HDR_FF) begin
                  phase_in = PH_HUNT2;
               end else begin
                  phase_in = PH_HUNT1;
                  count_in = '0;
               end
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // frame fields and crc
   always_ff @(posedge clock) begin
      if (step) begin
         length_ff <= length_in;
         crc_ff    <= crc_in;
         id_ff     <= id_in;
         instr_ff  <= instr_in;
         cklo_ff   <= cklo_in;
      end
   end

endmodule

// ----- hdl/crc16_framed_packet_receiver_top.sv -----
// ----------------------------------------------------------------------------
// crc16_framed_packet_receiver_top
// Framed serial packet receiver with crc-16 (0x8005) check. Streams out the
// parameter bytes of each frame and reports frame status, timeouts and
// overflows.
//
//   channel  direction  tdata                       tuser
//   req      in         byte_value                  command
//   rsp      out        data_byte .. param_count    kind
//
// One request per cycle is taken unless the rsp side stalls; each is held
// in the input register and its result, if any, is then registered in the
// output register. The frame state and crc step lie between those two
// registers. A stalled rsp side holds both registers, then drops req_tready.
// Reset is synchronous and returns the parser to hunting the header.
// ----------------------------------------------------------------------------
module crc16_framed_packet_receiver_top
   import crcfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_value
   input  logic        req_tuser,   // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // data_byte, param_index, frame_id,
                                    // frame_instruction, param_count, zero pad
   output logic [2:0]  rsp_tuser    // kind
);

   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff;
   logic       out_free;
   logic       step;
   logic       res_valid;
   rsp_type    res;

   // handshake control
   always_comb begin
      out_free     = !out_valid_ff || rsp_tready;
      step         = in_valid_ff && out_free;
      req_tready   = !in_valid_ff || out_free;
      in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);
      out_valid_in = out_free ? (step && res_valid) : out_valid_ff;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   // frame parser
   crcfr_parser #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .cmd        (in_cmd_ff),
      .byte_value (in_byte_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res_valid && out_free) begin
         out_ff <= res;
      end
   end

   // result ports
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {4'h0, out_ff.param_count, out_ff.frame_instruction, out_ff.frame_id,
                        out_ff.param_index, out_ff.data_byte};

endmodule

// ----- test/crcfr_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// crcfr_tb_pkg
// Frame checksum arithmetic shared by the stimulus side and the report
// checker of the framed packet receiver bench.
// ----------------------------------------------------------------------------
package crcfr_tb_pkg;

   import crcfr_pkg::CRC_POLY;

   // crc-16 advanced one data bit at a time, msb first
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0] data);
      logic [15:0] acc;
      logic        fb;
      acc = crc;
      for (int i = 7; i >= 0; i--) begin
         fb  = acc[15] ^ data[i];
         acc = {acc[14:0], 1'b0};
         if (fb) begin
            acc = acc ^ CRC_POLY;
         end
      end
      return acc;
   endfunction

endpackage

// ----- test/crcfr_report_checker.sv -----
// ----------------------------------------------------------------------------
// crcfr_report_checker
// Watches the request and report channels of the framed packet receiver,
// runs its own frame parser on every accepted request and compares each
// accepted report with the oldest predicted one.
// ----------------------------------------------------------------------------
module crcfr_report_checker
   import crcfr_pkg::*;
   import crcfr_tb_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   output int          mismatch_count,
   output int          awaited_count,
   output int          param_reports,
   output int          good_frames,
   output int          bad_frames,
   output int          timeouts_seen,
   output int          overflows_seen
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      P_SYNC1, P_SYNC2, P_SYNC3, P_RESERVED, P_ID, P_LEN_LO, P_LEN_HI,
      P_INSTR, P_PARAM, P_CK_LO, P_CK_HI
   } parse_phase_type;

   // parser state mirrored from the block
   parse_phase_type phase;
   int unsigned     bytes_in_frame;
   logic [15:0]     length_field;
   logic [15:0]     crc_acc;
   logic [7:0]      id_seen;
   logic [7:0]      instr_seen;
   logic [7:0]      ck_low;

   // predicted reports, oldest first
   rsp_type report_q[$];

   function automatic void resync();
      phase          = P_SYNC1;
      bytes_in_frame = 0;
   endfunction

   // report carrying the frame id, instruction and parameter count
   function automatic rsp_type frame_report(input logic [2:0] kind);
      rsp_type     r;
      logic [15:0] n_params;
      r                   = '0;
      n_params            = length_field - 16'd3;
      r.kind              = kind;
      r.frame_id          = id_seen;
      r.frame_instruction = instr_seen;
      r.param_count       = (length_field >= 16'd3) ? n_params[5:0] : 6'd0;
      return r;
   endfunction

   // one request through the frame parser
   task automatic advance_parser(input logic cmd, input logic [7:0] b);
      rsp_type     r;
      bit          emit;
      bit          good;
      int unsigned frame_end;
      logic [31:0] pos;
      r         = '0;
      emit      = 1'b0;
      frame_end = length_field + 5;
      if (cmd == CMD_TIMEOUT) begin
         r.kind = KIND_TIMEOUT;
         emit   = 1'b1;
         resync();
      end else if (phase == P_SYNC3 && b == HDR_FF) begin
         // surplus sync byte before the last header byte, not counted
      end else begin
         bytes_in_frame++;
         if (bytes_in_frame >= MAX_FRAME_BYTES) begin
            r.kind = KIND_OVERFLOW;
            emit   = 1'b1;
            resync();
         end else begin
            case (phase)
               P_SYNC1: begin
                  if (b == HDR_FF) phase = P_SYNC2;
                  else resync();
               end
               P_SYNC2: begin
                  if (b == HDR_FF) phase = P_SYNC3;
                  else resync();
               end
               P_SYNC3: begin
                  if (b == HDR_FD) begin
                     crc_acc = crc16_update(crc16_update(crc16_update(16'h0000, HDR_FF),
                                                         HDR_FF), HDR_FD);
                     phase   = P_RESERVED;
                  end else begin
                     resync();
                  end
               end
               P_RESERVED: begin
                  crc_acc = crc16_update(crc_acc, b);
                  phase   = P_ID;
               end
               P_ID: begin
                  crc_acc = crc16_update(crc_acc, b);
                  id_seen = b;
                  phase   = P_LEN_LO;
               end
               P_LEN_LO: begin
                  crc_acc      = crc16_update(crc_acc, b);
                  length_field = {8'h00, b};
                  phase        = P_LEN_HI;
               end
               P_LEN_HI: begin
                  crc_acc            = crc16_update(crc_acc, b);
                  length_field[15:8] = b;
                  phase              = P_INSTR;
               end
               P_INSTR: begin
                  crc_acc    = crc16_update(crc_acc, b);
                  instr_seen = b;
                  phase      = (bytes_in_frame >= frame_end) ? P_CK_LO : P_PARAM;
               end
               P_PARAM: begin
                  crc_acc       = crc16_update(crc_acc, b);
                  pos           = bytes_in_frame - 9;
                  r             = frame_report(KIND_PARAM);
                  r.data_byte   = b;
                  r.param_index = pos[5:0];
                  emit          = 1'b1;
                  if (bytes_in_frame >= frame_end) phase = P_CK_LO;
               end
               P_CK_LO: begin
                  ck_low = b;
                  phase  = P_CK_HI;
               end
               default: begin
                  good = (length_field >= 16'd3) && ({b, ck_low} == crc_acc);
                  r    = frame_report(good ? KIND_GOOD : KIND_BAD);
                  emit = 1'b1;
                  resync();
               end
            endcase
         end
      end
      if (emit) report_q.push_back(r);
   endtask

   // compare reports, then predict from the request of this edge
   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         resync();
         length_field = '0;
         crc_acc      = '0;
         id_seen      = '0;
         instr_seen   = '0;
         ck_low       = '0;
         report_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind              = rsp_tuser;
            got.data_byte         = rsp_tdata[7:0];
            got.param_index       = rsp_tdata[13:8];
            got.frame_id          = rsp_tdata[21:14];
            got.frame_instruction = rsp_tdata[29:22];
            got.param_count       = rsp_tdata[35:30];
            case (got.kind)
               KIND_PARAM:    param_reports++;
               KIND_GOOD:     good_frames++;
               KIND_BAD:      bad_frames++;
               KIND_TIMEOUT:  timeouts_seen++;
               KIND_OVERFLOW: overflows_seen++;
               default: ;
            endcase
            if (report_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected report, kind %0d data %02h", $time,
                           got.kind, got.data_byte);
            end else begin
               want = report_q.pop_front();
               if (got !== want || rsp_tdata[39:36] !== 4'h0) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: report mismatch, expected kind %0d data %02h idx %0d",
                              $time, want.kind, want.data_byte, want.param_index,
                              " id %02h instr %02h count %0d", want.frame_id,
                              want.frame_instruction, want.param_count);
                     $display("   got kind %0d data %02h idx %0d id %02h instr %02h",
                              got.kind, got.data_byte, got.param_index, got.frame_id,
                              got.frame_instruction, " count %0d pad %h",
                              got.param_count, rsp_tdata[39:36]);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) advance_parser(req_tuser, req_tdata);
      end
      awaited_count = report_q.size();
   end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Bench for the crc-16 framed packet receiver. Sends hand-picked frames,
// then random good, corrupt, short, oversized and cut-off frames mixed with
// line noise and timeouts, with random gaps and report stalls. Checking is
// done by the report checker placed beside the block.
// ----------------------------------------------------------------------------
module tb_top
   import crcfr_pkg::*;
   import crcfr_tb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LIMIT    = 64;
   localparam int TOTAL_REQUESTS = 1925;
   localparam int CALM_TAIL      = 250;
   localparam int RUN_LIMIT_NS   = 5_000_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int mismatch_count;
   int awaited_count;
   int param_reports;
   int good_frames;
   int bad_frames;
   int timeouts_seen;
   int overflows_seen;

   // stimulus bookkeeping
   bit          quiet   = 1'b0;
   bit          no_gaps = 1'b0;
   int          stall_left = 0;
   int          sent = 0;
   logic [7:0]  frame_bytes[$];
   logic [15:0] frame_crc;

   crc16_framed_packet_receiver_top #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   crcfr_report_checker #(
      .MAX_FRAME_BYTES(FRAME_LIMIT)
   ) report_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count),
      .param_reports  (param_reports),
      .good_frames    (good_frames),
      .bad_frames     (bad_frames),
      .timeouts_seen  (timeouts_seen),
      .overflows_seen (overflows_seen)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // report side stalls in short bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(1, 3) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // run limit
   initial begin
      #RUN_LIMIT_NS;
      $display("crc16_framed_packet_receiver_top test failed");
      $finish;
   end

   // one request, with an optional idle burst first; called at a falling edge
   task automatic push_request(input logic cmd, input logic [7:0] value);
      int gap;
      if (!quiet && !no_gaps && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic add_body_byte(input logic [7:0] b);
      frame_bytes.push_back(b);
      frame_crc = crc16_update(frame_crc, b);
   endtask

   // whole frame with random content and a correct checksum
   task automatic build_frame(input int extra_ff, input logic [15:0] len, input int n_params);
      frame_bytes.delete();
      frame_crc = 16'h0000;
      add_body_byte(HDR_FF);
      add_body_byte(HDR_FF);
      repeat (extra_ff) frame_bytes.push_back(HDR_FF);
      add_body_byte(HDR_FD);
      add_body_byte(8'($urandom_range(0, 255)));
      add_body_byte(8'($urandom_range(0, 255)));
      add_body_byte(len[7:0]);
      add_body_byte(len[15:8]);
      add_body_byte(8'($urandom_range(0, 255)));
      repeat (n_params) add_body_byte(8'($urandom_range(0, 255)));
      frame_bytes.push_back(frame_crc[7:0]);
      frame_bytes.push_back(frame_crc[15:8]);
   endtask

   task automatic send_frame(input int count);
      for (int i = 0; i < count; i++) push_request(CMD_BYTE, frame_bytes[i]);
   endtask

   initial begin : stimulus
      int          choice;
      int          extra;
      int          n_par;
      int          cut;
      int          k;
      logic [15:0] len;
      bit          drained;
      drained    = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_BYTE;
      req_tdata  = 8'h00;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // timeout while hunting, broken header, good frame with a surplus
      // sync byte, frame with too short a length
      push_request(CMD_TIMEOUT, 8'hFF);
      push_request(CMD_BYTE, HDR_FF);
      push_request(CMD_BYTE, 8'h00);
      build_frame(1, 16'd4, 1);
      send_frame(frame_bytes.size());
      build_frame(0, 16'd2, 0);
      send_frame(frame_bytes.size());

      // random frames and noise
      while (sent < TOTAL_REQUESTS) begin
         if (!drained && sent >= TOTAL_REQUESTS / 2) begin
            drained = 1'b1;
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (awaited_count != 0) @(negedge clock);
         end
         if (sent >= TOTAL_REQUESTS - CALM_TAIL) quiet = 1'b1;
         no_gaps = ($urandom_range(0, 3) == 0);
         extra   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         n_par   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 53) : $urandom_range(0, 8);
         choice  = $urandom_range(0, 99);
         if (choice < 55) begin
            // well-formed frame
            build_frame(extra, 16'(n_par + 3), n_par);
            send_frame(frame_bytes.size());
         end else if (choice < 65) begin
            // one checksum bit flipped
            build_frame(extra, 16'(n_par + 3), n_par);
            k = $urandom_range(1, 2);
            frame_bytes[frame_bytes.size() - k] ^= 8'h01 << $urandom_range(0, 7);
            send_frame(frame_bytes.size());
         end else if (choice < 72) begin
            // length below three, checksum otherwise right
            build_frame(extra, 16'($urandom_range(0, 2)), 0);
            send_frame(frame_bytes.size());
         end else if (choice < 76) begin
            // frame that runs past the size limit, sometimes on the checksum
            if ($urandom_range(0, 1) == 1) begin
               len   = 16'($urandom_range(57, 60));
               n_par = len - 3;
            end else begin
               len   = 16'($urandom_range(0, 65535));
               n_par = 57;
            end
            build_frame(extra, len, n_par);
            send_frame(frame_bytes.size());
         end else if (choice < 88) begin
            // frame cut off by a read timeout
            build_frame(extra, 16'(n_par + 3), n_par);
            cut = $urandom_range(1, frame_bytes.size() - 1);
            send_frame(cut);
            push_request(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
         end else begin
            // line noise, rich in header bytes
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 3))
                  0:       k = HDR_FF;
                  1:       k = HDR_FD;
                  default: k = $urandom_range(0, 255);
               endcase
               push_request(($urandom_range(0, 9) == 0) ? CMD_TIMEOUT : CMD_BYTE, 8'(k));
            end
         end
      end
      req_tvalid <= 1'b0;

      // drain, then wait for stray reports
      while (awaited_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("covered %0d requests: %0d parameter bytes, %0d good and %0d bad frames",
               sent, param_reports, good_frames, bad_frames);
      $display("plus %0d timeouts and %0d size overflows, with gaps and report stalls",
               timeouts_seen, overflows_seen);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("crc16_framed_packet_receiver_top test passed");
      end else begin
         $display("crc16_framed_packet_receiver_top test failed");
      end
      $finish;
   end

endmodule
